// ===== rtl/core/srl_pkg.sv =====
// Shared types and constants for the sequential record list.
package srl_pkg;

  localparam int KeyW = 32;
  localparam int PayW = 64;
  localparam int CmdW = 4;
  localparam int PosW = 7;
  localparam int StW  = 3;

  // Command codes of the input word.
  typedef enum logic [CmdW-1:0] {
    CMD_APPEND    = 4'd0,
    CMD_PREPEND   = 4'd1,
    CMD_INSERT    = 4'd2,
    CMD_READ      = 4'd3,
    CMD_FIND      = 4'd4,
    CMD_REM_KEY   = 4'd5,
    CMD_REM_FIRST = 4'd6,
    CMD_REM_LAST  = 4'd7,
    CMD_REM_SWAP  = 4'd8,
    CMD_SWAP      = 4'd9,
    CMD_REM_RANGE = 4'd10
  } cmd_e;

  // Status codes of the result word.
  localparam logic [StW-1:0] ST_OK     = 3'd0;
  localparam logic [StW-1:0] ST_FULL   = 3'd1;
  localparam logic [StW-1:0] ST_EMPTY  = 3'd2;
  localparam logic [StW-1:0] ST_NOKEY  = 3'd3;
  localparam logic [StW-1:0] ST_BADPOS = 3'd4;

  // What every cell of the chain does in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_WR
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       we2;
  } cell_op_t;

endpackage

// ===== rtl/core/srl_cell.sv =====
// One storage cell of the record chain with its compare and shift logic.
module srl_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                          clk_i,
  input  srl_pkg::cell_op_t             op_i,
  input  logic [IW-1:0]                 at_i,
  input  logic [IW-1:0]                 at2_i,
  input  logic signed [srl_pkg::KeyW-1:0] wr_key_i,
  input  logic [srl_pkg::PayW-1:0]      wr_pay_i,
  input  logic signed [srl_pkg::KeyW-1:0] wr2_key_i,
  input  logic [srl_pkg::PayW-1:0]      wr2_pay_i,
  input  logic signed [srl_pkg::KeyW-1:0] left_key_i,
  input  logic [srl_pkg::PayW-1:0]      left_pay_i,
  input  logic signed [srl_pkg::KeyW-1:0] right_key_i,
  input  logic [srl_pkg::PayW-1:0]      right_pay_i,
  input  logic                          valid_i,
  input  logic signed [srl_pkg::KeyW-1:0] search_key_i,
  input  logic                          eq_seen_i,
  input  logic                          ge_seen_i,
  output logic                          eq_seen_o,
  output logic                          ge_seen_o,
  output logic                          eq_first_o,
  output logic                          ge_first_o,
  output logic signed [srl_pkg::KeyW-1:0] key_o,
  output logic [srl_pkg::PayW-1:0]      pay_o
);
  import srl_pkg::*;

  localparam logic [IW-1:0] Me = IW'(IDX);

  logic signed [KeyW-1:0] key_q, key_d;
  logic [PayW-1:0]        pay_q, pay_d;
  logic                   eq_hit, ge_hit;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    case (op_i.mode)
      CELL_SHR: begin
        if (Me == at_i) begin
          key_d = wr_key_i;
          pay_d = wr_pay_i;
        end else if (Me > at_i) begin
          key_d = left_key_i;
          pay_d = left_pay_i;
        end
      end
      CELL_SHL: begin
        if (Me >= at_i) begin
          key_d = right_key_i;
          pay_d = right_pay_i;
        end
      end
      CELL_WR: begin
        if (Me == at_i) begin
          key_d = wr_key_i;
          pay_d = wr_pay_i;
        end
        if (op_i.we2 && Me == at2_i) begin
          key_d = wr2_key_i;
          pay_d = wr2_pay_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign eq_hit     = valid_i && (key_q == search_key_i);
  assign ge_hit     = valid_i && !(key_q < search_key_i);
  assign eq_first_o = eq_hit && !eq_seen_i;
  assign ge_first_o = ge_hit && !ge_seen_i;
  assign eq_seen_o  = eq_seen_i || eq_hit;
  assign ge_seen_o  = ge_seen_i || ge_hit;
  assign key_o      = key_q;
  assign pay_o      = pay_q;

endmodule

// ===== rtl/core/sequential_record_list.sv =====
// Top level of the sequential record list: command sequencer over a chain of record cells.
// A command word is latched when accepted, then passes the search cycle (S_EVAL) and the
// update cycle (S_EXEC), at whose end the result strobe is registered; removing a range of
// records adds one more shift of the chain (S_RANGE) for every record after the first.
// A new command word is taken only once the previous one reaches its last update cycle.
// Reset: asynchronous, active low; the record count clears to zero, record cells are not cleared.
// The receiver cannot stall: every result strobe is shown for exactly one cycle.
module sequential_record_list #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [srl_pkg::CmdW-1:0]        command_i,
  input  logic signed [srl_pkg::KeyW-1:0] key_i,
  input  logic [srl_pkg::PayW-1:0]        payload_i,
  input  logic [srl_pkg::PosW-1:0]        pos_a_i,
  input  logic [srl_pkg::PosW-1:0]        pos_b_i,
  output logic                            done_o,
  output logic [srl_pkg::StW-1:0]         status_o,
  output logic signed [srl_pkg::KeyW-1:0] found_key_o,
  output logic [srl_pkg::PayW-1:0]        found_payload_o,
  output logic [srl_pkg::PosW-1:0]        count_o
);
  import srl_pkg::*;

  // Widths: cell index, record count and a common width for position compares.
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > PosW) ? CW : PosW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EXEC,
    S_RANGE
  } state_e;

  state_e state_q;

  // Latched command word.
  logic [CmdW-1:0]        cmd_q;
  logic signed [KeyW-1:0] key_q;
  logic [PayW-1:0]        pay_q;
  logic [PosW-1:0]        pa_q, pb_q;

  logic [CW-1:0] count_q, count_d;
  logic [XW-1:0] rem_q, rem_d;

  // Results of the search cycle.
  logic                   eq_found_q;
  logic [IW-1:0]          eq_idx_q, ge_idx_q;
  logic signed [KeyW-1:0] eq_key_q, rda_key_q, rdb_key_q, last_key_q;
  logic [PayW-1:0]        eq_pay_q, rda_pay_q, rdb_pay_q, last_pay_q;

  // Result word registers.
  logic                   done_q;
  logic [StW-1:0]         status_q;
  logic signed [KeyW-1:0] fkey_q;
  logic [PayW-1:0]        fpay_q;
  logic [PosW-1:0]        cnt_out_q;

  // Cell chain wiring.
  cell_op_t               op;
  logic [IW-1:0]          at, at2;
  logic signed [KeyW-1:0] wr_key, wr2_key;
  logic [PayW-1:0]        wr_pay, wr2_pay;
  logic signed [KeyW-1:0] cell_key [CAPACITY];
  logic [PayW-1:0]        cell_pay [CAPACITY];
  logic [CAPACITY:0]      eq_seen, ge_seen;
  logic [CAPACITY-1:0]    eq_first, ge_first, cell_valid;

  // Positions widened to a common width so that any capacity compares correctly.
  logic [XW-1:0] cnt_x, pa_x, pb_x, span_x;
  logic [IW-1:0] pa_idx, pb_idx;

  assign cnt_x  = XW'(count_q);
  assign pa_x   = XW'(pa_q);
  assign pb_x   = XW'(pb_q);
  assign span_x = pb_x - pa_x + XW'(1);
  assign pa_idx = IW'(pa_x - XW'(1));
  assign pb_idx = IW'(pb_x - XW'(1));

  assign eq_seen[0] = 1'b0;
  assign ge_seen[0] = 1'b0;

  // The chain: each cell hands its record to both neighbours every cycle.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [KeyW-1:0] lk, rk;
    logic [PayW-1:0]        lp, rp;

    if (g == 0) begin : g_left_end
      assign lk = '0;
      assign lp = '0;
    end else begin : g_left
      assign lk = cell_key[g-1];
      assign lp = cell_pay[g-1];
    end
    if (g == CAPACITY - 1) begin : g_right_end
      assign rk = '0;
      assign rp = '0;
    end else begin : g_right
      assign rk = cell_key[g+1];
      assign rp = cell_pay[g+1];
    end

    assign cell_valid[g] = (CW'(g) < count_q);

    srl_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .at_i         (at),
      .at2_i        (at2),
      .wr_key_i     (wr_key),
      .wr_pay_i     (wr_pay),
      .wr2_key_i    (wr2_key),
      .wr2_pay_i    (wr2_pay),
      .left_key_i   (lk),
      .left_pay_i   (lp),
      .right_key_i  (rk),
      .right_pay_i  (rp),
      .valid_i      (cell_valid[g]),
      .search_key_i (key_q),
      .eq_seen_i    (eq_seen[g]),
      .ge_seen_i    (ge_seen[g]),
      .eq_seen_o    (eq_seen[g+1]),
      .ge_seen_o    (ge_seen[g+1]),
      .eq_first_o   (eq_first[g]),
      .ge_first_o   (ge_first[g]),
      .key_o        (cell_key[g]),
      .pay_o        (cell_pay[g])
    );
  end

  // Search cycle: encode the first key match, the insertion point and the records
  // at both positions and at the tail. Each cell contributes independently.
  logic [IW-1:0]          eq_enc, ge_enc, last_idx;
  logic signed [KeyW-1:0] eq_k, rda_k, rdb_k, last_k;
  logic [PayW-1:0]        eq_p, rda_p, rdb_p, last_p;

  assign last_idx = IW'(count_q - CW'(1));

  always_comb begin
    eq_enc = '0;
    ge_enc = '0;
    eq_k   = '0;
    eq_p   = '0;
    rda_k  = '0;
    rda_p  = '0;
    rdb_k  = '0;
    rdb_p  = '0;
    last_k = '0;
    last_p = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq_first[i]) begin
        eq_enc = eq_enc | IW'(i);
        eq_k   = eq_k | cell_key[i];
        eq_p   = eq_p | cell_pay[i];
      end
      if (ge_first[i]) begin
        ge_enc = ge_enc | IW'(i);
      end
      if (IW'(i) == pa_idx) begin
        rda_k = rda_k | cell_key[i];
        rda_p = rda_p | cell_pay[i];
      end
      if (IW'(i) == pb_idx) begin
        rdb_k = rdb_k | cell_key[i];
        rdb_p = rdb_p | cell_pay[i];
      end
      if (IW'(i) == last_idx) begin
        last_k = last_k | cell_key[i];
        last_p = last_p | cell_pay[i];
      end
    end
  end

  // Update cycle: decide the chain operation and the result word.
  logic [StW-1:0]         status_d;
  logic signed [KeyW-1:0] fkey_d;
  logic [PayW-1:0]        fpay_d;
  logic                   fin;
  logic                   in_exec;

  assign in_exec = (state_q == S_EXEC);

  always_comb begin
    op.mode  = CELL_HOLD;
    op.we2   = 1'b0;
    at       = '0;
    at2      = '0;
    wr_key   = key_q;
    wr_pay   = pay_q;
    wr2_key  = rda_key_q;
    wr2_pay  = rda_pay_q;
    count_d  = count_q;
    rem_d    = rem_q;
    status_d = ST_OK;
    fkey_d   = '0;
    fpay_d   = '0;
    fin      = 1'b1;
    if (state_q == S_RANGE) begin
      // Each cycle removes one more record at the start of the range.
      op.mode = CELL_SHL;
      at      = pa_idx;
      count_d = count_q - CW'(1);
      rem_d   = rem_q - XW'(1);
      fin     = (rem_q == XW'(1));
    end else if (in_exec) begin
      unique case (cmd_q) inside
        CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
          if (count_q == CW'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            op.mode = CELL_SHR;
            count_d = count_q + CW'(1);
            if (cmd_q == CMD_APPEND) begin
              at = IW'(count_q);
            end else if (cmd_q == CMD_PREPEND) begin
              at = '0;
            end else begin
              at = ge_idx_q;
            end
          end
        end
        CMD_READ, CMD_FIND, CMD_REM_KEY, CMD_REM_FIRST, CMD_REM_LAST,
        CMD_REM_SWAP, CMD_SWAP, CMD_REM_RANGE: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            unique case (cmd_q) inside
              CMD_READ: begin
                if (pa_q == '0 || pa_x > cnt_x) begin
                  status_d = ST_BADPOS;
                end else begin
                  fkey_d = rda_key_q;
                  fpay_d = rda_pay_q;
                end
              end
              CMD_FIND, CMD_REM_KEY, CMD_REM_SWAP: begin
                if (!eq_found_q) begin
                  status_d = ST_NOKEY;
                end else if (cmd_q == CMD_FIND) begin
                  fkey_d = eq_key_q;
                  fpay_d = eq_pay_q;
                end else if (cmd_q == CMD_REM_KEY) begin
                  op.mode = CELL_SHL;
                  at      = eq_idx_q;
                  count_d = count_q - CW'(1);
                end else begin
                  op.mode = CELL_WR;
                  at      = eq_idx_q;
                  wr_key  = last_key_q;
                  wr_pay  = last_pay_q;
                  count_d = count_q - CW'(1);
                end
              end
              CMD_REM_FIRST: begin
                op.mode = CELL_SHL;
                at      = '0;
                count_d = count_q - CW'(1);
              end
              CMD_REM_LAST: begin
                count_d = count_q - CW'(1);
              end
              CMD_SWAP: begin
                if (pa_q == '0 || pb_q == '0 || pa_x > cnt_x || pb_x > cnt_x) begin
                  status_d = ST_BADPOS;
                end else begin
                  op.mode = CELL_WR;
                  op.we2  = 1'b1;
                  at      = pa_idx;
                  wr_key  = rdb_key_q;
                  wr_pay  = rdb_pay_q;
                  at2     = pb_idx;
                end
              end
              default: begin
                if (pa_q == '0 || pb_x > cnt_x || pa_x > pb_x) begin
                  status_d = ST_BADPOS;
                end else begin
                  op.mode = CELL_SHL;
                  at      = pa_idx;
                  count_d = count_q - CW'(1);
                  rem_d   = span_x - XW'(1);
                  fin     = (span_x == XW'(1));
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Busy drops in the last update cycle so that the next word can enter at once.
  assign busy = !((state_q == S_IDLE) ||
                  ((state_q == S_EXEC || state_q == S_RANGE) && fin));

  // Command word latch and search results; no reset is needed on these.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= command_i;
      key_q <= key_i;
      pay_q <= payload_i;
      pa_q  <= pos_a_i;
      pb_q  <= pos_b_i;
    end
    if (state_q == S_EVAL) begin
      eq_found_q <= eq_seen[CAPACITY];
      eq_idx_q   <= eq_enc;
      ge_idx_q   <= ge_seen[CAPACITY] ? ge_enc : IW'(count_q);
      eq_key_q   <= eq_k;
      eq_pay_q   <= eq_p;
      rda_key_q  <= rda_k;
      rda_pay_q  <= rda_p;
      rdb_key_q  <= rdb_k;
      rdb_pay_q  <= rdb_p;
      last_key_q <= last_k;
      last_pay_q <= last_p;
    end
  end

  // Sequencer state, record count and the registered result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rem_q     <= '0;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      fkey_q    <= '0;
      fpay_q    <= '0;
      cnt_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: ;
        S_EVAL: state_q <= S_EXEC;
        S_EXEC, S_RANGE: begin
          count_q <= count_d;
          rem_q   <= rem_d;
          if (fin) begin
            state_q   <= S_IDLE;
            done_q    <= 1'b1;
            cnt_out_q <= PosW'(count_d);
            if (state_q == S_EXEC) begin
              status_q <= status_d;
              fkey_q   <= fkey_d;
              fpay_q   <= fpay_d;
            end else begin
              status_q <= ST_OK;
              fkey_q   <= '0;
              fpay_q   <= '0;
            end
          end else begin
            state_q <= S_RANGE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (start && !busy) begin
        state_q <= S_EVAL;
      end
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_key_o     = fkey_q;
  assign found_payload_o = fpay_q;
  assign count_o         = cnt_out_q;

  // The record count never passes the capacity of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(CAPACITY))
    else $error("record count above capacity");

  // An accepted command word always starts a search cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> state_q == S_EVAL)
    else $error("accepted word did not enter the search cycle");

  // A full status is only reported while the list really is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q == ST_FULL |-> count_q == CW'(CAPACITY))
    else $error("full status with free room");

  // A result strobe only ever follows an update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(state_q) == S_EXEC || $past(state_q) == S_RANGE)
    else $error("result strobe without an update cycle");

endmodule
